// File: rtl/char_queue_to_stack_mover_core_defines.svh
// assertion macros shared by the character queue to stack mover rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef CHAR_QUEUE_TO_STACK_MOVER_CORE_DEFINES_SVH
`define CHAR_QUEUE_TO_STACK_MOVER_CORE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define CQSM_ASSERT_IMP(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define CQSM_ASSERT_NXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: rtl/cqsm_pkg.sv
// shared types, codes and default sizes for the queue to stack mover
// no dependencies
`default_nettype none

package cqsm_pkg;

  // default store depths
  localparam int unsigned Q_DEPTH_DEF = 512;
  localparam int unsigned S_DEPTH_DEF = 512;

  // field widths
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  // stream word widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  // entries in the command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;

  // opcodes on the request side
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // status codes on the result side
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_CLIP = 2'd2;

  // classified command kind
  typedef enum logic [1:0] {
    K_APPEND,
    K_MOVE,
    K_DELETE,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] ch;
    logic [CNT_W-1:0]  cnt;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CHAR_W-1:0] stack_top;
    logic [CHAR_W-1:0] queue_front;
    logic [CNT_W-1:0]  done_count;
    logic [CNT_W-1:0]  stack_count;
    logic [CNT_W-1:0]  queue_count;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/cqsm_ram.sv
// generic simple dual port ram with registered read data
// no dependencies
`default_nettype none

module cqsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cqsm_front.sv
// front end: accepts requests, decodes the opcode and queues commands
// depends on cqsm_pkg and the assertion macro header
`default_nettype none
`include "char_queue_to_stack_mover_core_defines.svh"

module cqsm_front import cqsm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // char_in, count
  input  wire logic [OP_W-1:0]      s_axis_tuser,  // op
  output logic                      cmd_valid_o,
  output cmd_t                      cmd_o,
  input  wire logic                 cmd_ready_i
);

  localparam int unsigned PW = $clog2(CMDQ_DEPTH);
  localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t           slot_q [CMDQ_DEPTH];
  logic [PW-1:0]  wptr_q, wptr_d;
  logic [PW-1:0]  rptr_q, rptr_d;
  logic [CW-1:0]  fill_q, fill_d;
  kind_e          kind;
  cmd_t           in_cmd;
  logic           push;
  logic           pop;

  // opcode decode
  always_comb begin
    unique case (s_axis_tuser)
      OP_APPEND: kind = K_APPEND;
      OP_MOVE:   kind = K_MOVE;
      OP_DELETE: kind = K_DELETE;
      default:   kind = K_NOP;
    endcase
  end

  assign in_cmd.kind = kind;
  assign in_cmd.ch   = s_axis_tdata[0 +: CHAR_W];
  assign in_cmd.cnt  = s_axis_tdata[CHAR_W +: CNT_W];

  assign s_axis_tready = (fill_q != CW'(CMDQ_DEPTH));
  assign cmd_valid_o   = (fill_q != '0);
  assign cmd_o         = slot_q[rptr_q];

  assign push = s_axis_tvalid && s_axis_tready;
  assign pop  = cmd_valid_o && cmd_ready_i;

  // pointer and fill update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // command slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= in_cmd;
    end
  end

  `CQSM_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CW'(CMDQ_DEPTH), "command queue overfilled")
  `CQSM_ASSERT_NXT(a_fill_up, push && !pop, fill_q == $past(fill_q) + 1'b1, "fill not raised")
  `CQSM_ASSERT_NXT(a_fill_dn, pop && !push, fill_q == $past(fill_q) - 1'b1, "fill not lowered")

endmodule

`default_nettype wire

// File: rtl/cqsm_back.sv
// back end: runs append, move and delete against the queue and stack stores
// depends on cqsm_pkg, cqsm_ram and the assertion macro header
`default_nettype none
`include "char_queue_to_stack_mover_core_defines.svh"

module cqsm_back import cqsm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = Q_DEPTH_DEF,
  parameter int unsigned STACK_DEPTH = S_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_ready_o,
  input  wire logic out_free_i,
  output logic      res_valid_o,
  output res_t      res_o
);

  localparam int unsigned QA = $clog2(QUEUE_DEPTH);
  localparam int unsigned SA = $clog2(STACK_DEPTH);
  localparam int unsigned QW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W0 = (QW > SW) ? QW : SW;
  localparam int unsigned WW = (W0 > CNT_W) ? W0 : CNT_W;
  localparam int unsigned TW = WW + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOVE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_CAPT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [QA-1:0]     head_q, head_d;
  logic [QA-1:0]     tail_q, tail_d;
  logic [QW-1:0]     qfill_q, qfill_d;
  logic [SW-1:0]     sfill_q, sfill_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  done_q, done_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [CHAR_W-1:0] front_q, front_d;
  logic [CHAR_W-1:0] top_q, top_d;

  logic              q_we, q_re, s_we, s_re;
  logic [QA-1:0]     q_raddr;
  logic [SA-1:0]     s_waddr, s_raddr;
  logic [CHAR_W-1:0] q_rdata, s_rdata;

  logic [WW-1:0]     cnt_w, qf_w, sf_w, room_w, mv_lim, mv_n_w, dl_n_w;
  logic [CNT_W-1:0]  mv_n, dl_n;
  logic              mv_clip, dl_clip, q_full;
  logic [SW-1:0]     sfill_dl;
  logic [TW-1:0]     mv_tot;

  // clip limits for move and delete
  assign cnt_w   = WW'(cmd_i.cnt);
  assign qf_w    = WW'(qfill_q);
  assign sf_w    = WW'(sfill_q);
  assign room_w  = WW'(STACK_DEPTH) - sf_w;
  assign mv_lim  = (qf_w < room_w) ? qf_w : room_w;
  assign mv_clip = (mv_lim < cnt_w);
  assign mv_n_w  = mv_clip ? mv_lim : cnt_w;
  assign mv_n    = mv_n_w[CNT_W-1:0];
  assign dl_clip = (sf_w < cnt_w);
  assign dl_n_w  = dl_clip ? sf_w : cnt_w;
  assign dl_n    = dl_n_w[CNT_W-1:0];
  assign sfill_dl = sfill_q - SW'(dl_n);
  assign q_full  = (qfill_q >= QW'(QUEUE_DEPTH));

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    qfill_d     = qfill_q;
    sfill_d     = sfill_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    done_d      = done_q;
    stat_d      = stat_q;
    front_d     = front_q;
    top_d       = top_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    q_we        = 1'b0;
    q_re        = 1'b0;
    q_raddr     = head_q;
    s_we        = 1'b0;
    s_re        = 1'b0;
    s_waddr     = sfill_q[SA-1:0];
    s_raddr     = SA'(sfill_q - 1'b1);

    unique case (state_q)
      S_IDLE: begin
        done_d = '0;
        stat_d = STAT_OK;
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            K_APPEND: begin
              cmd_ready_o = out_free_i;
              if (q_full) begin
                stat_d = STAT_FULL;
              end else begin
                q_we    = out_free_i;
                tail_d  = (tail_q == QA'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                qfill_d = qfill_q + 1'b1;
                done_d  = CNT_W'(1);
                if (qfill_q == '0) begin
                  front_d = cmd_i.ch;
                end
              end
              res_valid_o = out_free_i;
            end
            K_MOVE: begin
              done_d = mv_n;
              stat_d = mv_clip ? STAT_CLIP : STAT_OK;
              if (mv_n == '0) begin
                cmd_ready_o = out_free_i;
                res_valid_o = out_free_i;
              end else begin
                cmd_ready_o = 1'b1;
                rem_d       = mv_n;
                pend_d      = 1'b0;
                state_d     = S_MOVE;
              end
            end
            K_DELETE: begin
              done_d  = dl_n;
              stat_d  = dl_clip ? STAT_CLIP : STAT_OK;
              sfill_d = sfill_dl;
              if ((dl_n != '0) && (sfill_dl != '0)) begin
                cmd_ready_o = 1'b1;
                state_d     = S_FETCH;
              end else begin
                cmd_ready_o = out_free_i;
                res_valid_o = out_free_i;
              end
            end
            default: begin
              cmd_ready_o = out_free_i;
              res_valid_o = out_free_i;
            end
          endcase
          // hold state when the quick path cannot hand off its result
          if (!cmd_ready_o) begin
            tail_d  = tail_q;
            qfill_d = qfill_q;
            sfill_d = sfill_q;
            front_d = front_q;
            done_d  = done_q;
            stat_d  = stat_q;
          end
        end
      end
      S_MOVE: begin
        // write the byte read last cycle, read the next one
        if (pend_q) begin
          s_we    = 1'b1;
          sfill_d = sfill_q + 1'b1;
        end
        if (rem_q != '0) begin
          q_re    = 1'b1;
          head_d  = (head_q == QA'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          qfill_d = qfill_q - 1'b1;
          rem_d   = rem_q - 1'b1;
          pend_d  = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        q_re    = 1'b1;
        s_re    = 1'b1;
        state_d = S_CAPT;
      end
      S_CAPT: begin
        front_d = q_rdata;
        top_d   = s_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result fields from the post-step state
  assign res_o.queue_count = CNT_W'(qfill_d);
  assign res_o.stack_count = CNT_W'(sfill_d);
  assign res_o.done_count  = done_d;
  assign res_o.queue_front = (qfill_d != '0) ? front_d : '0;
  assign res_o.stack_top   = (sfill_d != '0) ? top_d : '0;
  assign res_o.status      = stat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      qfill_q <= '0;
      sfill_q <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      qfill_q <= qfill_d;
      sfill_q <= sfill_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
    end
  end

  // cached bytes and result fields
  always_ff @(posedge clk_i) begin
    done_q  <= done_d;
    stat_q  <= stat_d;
    front_q <= front_d;
    top_q   <= top_d;
  end

  // queue store
  cqsm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q),
    .wdata_i (cmd_i.ch),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // stack store
  cqsm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (q_rdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign mv_tot = TW'(qfill_q) + TW'(sfill_q) + TW'(pend_q);

  `CQSM_ASSERT_IMP(a_fill_bound, 1'b1, (qfill_q <= QW'(QUEUE_DEPTH)) && (sfill_q <= SW'(STACK_DEPTH)), "fill above depth")
  `CQSM_ASSERT_IMP(a_move_keep, (state_q == S_MOVE) && ($past(state_q) == S_MOVE), mv_tot == $past(mv_tot), "bytes lost in move")
  `CQSM_ASSERT_NXT(a_res_idle, res_valid_o, state_q == S_IDLE, "sequencer busy after result")

endmodule

`default_nettype wire

// File: rtl/char_queue_to_stack_mover_core.sv
// Character queue to stack mover, top level.
// Requests enter on the s_axis channel: tuser carries the opcode (append, move,
// delete), tdata carries the byte to append and the byte count. Each request
// yields exactly one result on the m_axis channel with both fill levels, the
// number of bytes handled, the oldest queued byte, the top stack byte and a
// status (ok, append dropped on a full queue, count clipped).
// A two-entry command queue decouples the decoder from the executing sequencer,
// so requests are taken while a result waits in the output register.
// Appends, no-ops, moves or deletes that handle nothing, and deletes that
// empty the stack go from the command queue through the idle sequencer into
// the output register. A delete that leaves bytes on the stack runs the
// fetch, capture and done states to reread front and top; a move first
// copies one byte per cycle through the registered read port of the queue
// memory, then runs them too. Sustained rate is one append per cycle while
// m_axis_tready is high; other requests hold the sequencer until done.
// Reset clears fill levels and pointers at once, the stores themselves are
// not cleared. When m_axis_tready is low the result is held, the sequencer
// stalls on its next result, s_axis_tready drops once the command queue fills.
// depends on cqsm_pkg, cqsm_front, cqsm_back and cqsm_ram
`default_nettype none

module char_queue_to_stack_mover_core import cqsm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = Q_DEPTH_DEF,
  parameter int unsigned STACK_DEPTH = S_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // char_in, count, zero pad
  input  wire logic [OP_W-1:0]       s_axis_tuser,  // op
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // queue_count, stack_count,
                                                    // done_count, queue_front,
                                                    // stack_top, zero pad
  output logic [STAT_W-1:0]          m_axis_tuser   // status
);

  localparam int unsigned RES_DATA_W = 3 * CNT_W + 2 * CHAR_W;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  logic res_valid;
  res_t res;
  logic out_free;
  logic m_valid_q;
  res_t m_res_q;

  cqsm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  cqsm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_res_q <= res;
    end
  end

  // pack result fields, lowest first
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.status;
  assign m_axis_tdata  = {{(OUT_DATA_W - RES_DATA_W){1'b0}},
                          m_res_q.stack_top,
                          m_res_q.queue_front,
                          m_res_q.done_count,
                          m_res_q.stack_count,
                          m_res_q.queue_count};

endmodule

`default_nettype wire
